### rtl/mpt_pkg.sv
// Package for the multiplexed periodic timers: sizes, codes, types and
// the base-rate merge function. Depends on nothing; every rtl file but mpt_ram uses it.
`default_nettype none
package mpt_pkg;

  localparam int TIMERS = 8;
  localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int RATE_W = 10;
  localparam int FREQ_IN_W = 16;
  localparam int ID_IN_W = 16;
  localparam int RES_ID_W = 3;
  localparam int MAX_OUT = 8;
  localparam int FIRE_CNT_W = $clog2(MAX_OUT + 1);

  localparam logic [RATE_W-1:0] MAX_RATE = 10'd1000;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [RATE_W-1:0] rate_t;

  // One slot entry as held in the slot RAM.
  typedef struct packed {
    rate_t freq;
    rate_t count;
    rate_t period;
  } word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       tick_pr;
    logic       tick_end;
    logic       scan_pr;
    logic       commit;
    logic       div_start;
    logic       div_new;
    logic       rt_wr;
    logic       np_wr;
    logic       emit_ack;
    logic [1:0] ack_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_tick;
    logic in_setdel;
    logic in_bad;
    logic idx_last;
    logic idx_active;
    logic full;
    logic rate_chg;
    logic rate_zero;
    logic is_set;
    logic div_done;
  } stat_t;

  // Folds one active frequency into the running base rate.
  function automatic rate_t merge_rate(input rate_t acc, input rate_t f);
    rate_t r;
    if (f inside {10'd1, 10'd2, 10'd25, 10'd50, 10'd100, 10'd200}) begin
      r = (f > acc) ? f : acc;
    end else begin
      r = MAX_RATE;
    end
    return r;
  endfunction

  // Slot number as reported on the result port, masked to its width.
  function automatic logic [RES_ID_W-1:0] slot_to_id(input slot_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[RES_ID_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/mpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                                         clk,
  input  wire                                         we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                            wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/mpt_div.sv
// Restoring divider, one quotient bit per cycle, for period = base / freq.
// Depends on mpt_pkg.
`default_nettype none
module mpt_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire  mpt_pkg::rate_t dividend,
  input  wire  mpt_pkg::rate_t divisor,
  output logic                 done,
  output mpt_pkg::rate_t       quotient
);

  localparam int W = mpt_pkg::RATE_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W:0]       rem_sh;
  logic [W+1:0]     diff;

  always_comb begin
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    rem_sh = {rem_r[W-1:0], quo_r[W-1]};
    diff = {1'b0, rem_sh} - {2'b00, dsr_r};
    if (start) begin
      cnt_nxt = CNT_W'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      if (!diff[W+1]) begin
        rem_nxt = diff[W:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/mpt_datapath.sv
// Datapath of the timers: slot RAM, active bits, walk index, base rate,
// divider and result registers. Depends on mpt_pkg, mpt_ram and mpt_div.
`default_nettype none
module mpt_datapath (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  mpt_pkg::cmd_t           cmd,
  output mpt_pkg::stat_t                st,
  input  wire  [1:0]                    in_op,
  input  wire  [mpt_pkg::FREQ_IN_W-1:0] in_freq_hz,
  input  wire  [mpt_pkg::ID_IN_W-1:0]   in_timer_id,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic [1:0]                    out_status,
  output logic [mpt_pkg::RES_ID_W-1:0]  out_result_id,
  output logic [mpt_pkg::RATE_W-1:0]    out_base_rate_hz,
  output logic                          out_last
);

  localparam int T = mpt_pkg::TIMERS;
  localparam mpt_pkg::slot_t LAST_IDX = mpt_pkg::slot_t'(T - 1);

  logic [T-1:0]                    active_r, active_nxt;
  mpt_pkg::slot_t                  idx_r, idx_nxt;
  mpt_pkg::slot_t                  id_r, id_nxt;
  mpt_pkg::slot_t                  slot_r, slot_nxt;
  mpt_pkg::slot_t                  pend_id_r, pend_id_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic                            set_r, set_nxt;
  logic                            free_r, free_nxt;
  logic [mpt_pkg::FIRE_CNT_W-1:0]  fires_r, fires_nxt;
  mpt_pkg::rate_t                  freq_r, freq_nxt;
  mpt_pkg::rate_t                  acc_r, acc_nxt;
  mpt_pkg::rate_t                  base_r, base_nxt;
  mpt_pkg::rate_t                  new_rate;

  logic                            strobe_r, strobe_nxt;
  logic                            kind_r, kind_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [mpt_pkg::RES_ID_W-1:0]    rid_r, rid_nxt;
  mpt_pkg::rate_t                  obase_r, obase_nxt;
  logic                            last_r, last_nxt;

  logic                            we;
  mpt_pkg::slot_t                  waddr;
  mpt_pkg::word_t                  wdata;
  mpt_pkg::word_t                  rword;
  logic [$bits(mpt_pkg::word_t)-1:0] rdata;
  mpt_pkg::rate_t                  cnt1;
  logic                            fire;
  logic                            div_done;
  mpt_pkg::rate_t                  quo;
  mpt_pkg::rate_t                  div_dsr;
  logic                            in_set, in_del;

  assign rword = mpt_pkg::word_t'(rdata);

  mpt_ram #(
    .WIDTH($bits(mpt_pkg::word_t)),
    .DEPTH(T)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign div_dsr = cmd.div_new ? freq_r : rword.freq;

  mpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(base_r),
    .divisor (div_dsr),
    .done    (div_done),
    .quotient(quo)
  );

  assign in_set = (in_op == mpt_pkg::OP_SET);
  assign in_del = (in_op == mpt_pkg::OP_DEL);
  assign new_rate = set_r ? mpt_pkg::merge_rate(acc_r, freq_r) : acc_r;
  assign cnt1 = rword.count + 1'b1;
  assign fire = (cnt1 >= rword.period);

  always_comb begin
    st.in_tick = (in_op == mpt_pkg::OP_TICK);
    st.in_setdel = in_set || in_del;
    st.in_bad = (in_set && ((in_freq_hz == '0) ||
                            (in_freq_hz > mpt_pkg::FREQ_IN_W'(mpt_pkg::MAX_RATE)))) ||
                (in_del && (in_timer_id >= mpt_pkg::ID_IN_W'(T)));
    st.idx_last = (idx_r == LAST_IDX);
    st.idx_active = active_r[idx_r];
    st.full = set_r && !free_r;
    st.rate_chg = (new_rate != base_r);
    st.rate_zero = (new_rate == '0);
    st.is_set = set_r;
    st.div_done = div_done;
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt = idx_r;
    id_nxt = id_r;
    slot_nxt = slot_r;
    pend_id_nxt = pend_id_r;
    pend_v_nxt = pend_v_r;
    set_nxt = set_r;
    free_nxt = free_r;
    fires_nxt = fires_r;
    freq_nxt = freq_r;
    acc_nxt = acc_r;
    base_nxt = base_r;
    strobe_nxt = 1'b0;
    kind_nxt = kind_r;
    status_nxt = status_r;
    rid_nxt = rid_r;
    obase_nxt = obase_r;
    last_nxt = last_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = rword;

    if (cmd.load) begin
      idx_nxt = '0;
      id_nxt = mpt_pkg::slot_t'(in_timer_id);
      set_nxt = in_set;
      freq_nxt = mpt_pkg::rate_t'(in_freq_hz);
      free_nxt = 1'b0;
      acc_nxt = '0;
      fires_nxt = '0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.idx_inc) begin
      idx_nxt = mpt_pkg::slot_t'(idx_r + 1'b1);
    end

    // Tick: advance the count, clear it on reaching the period. A fire is
    // held back one step so that the final one can carry the last flag.
    if (cmd.tick_pr && active_r[idx_r]) begin
      we = 1'b1;
      wdata.count = fire ? '0 : cnt1;
      if (fire && (fires_r < mpt_pkg::FIRE_CNT_W'(mpt_pkg::MAX_OUT))) begin
        if (pend_v_r) begin
          strobe_nxt = 1'b1;
          kind_nxt = mpt_pkg::KIND_FIRE;
          status_nxt = mpt_pkg::ST_OK;
          rid_nxt = mpt_pkg::slot_to_id(pend_id_r);
          obase_nxt = base_r;
          last_nxt = 1'b0;
        end
        pend_v_nxt = 1'b1;
        pend_id_nxt = idx_r;
        fires_nxt = fires_r + 1'b1;
      end
    end

    if (cmd.tick_end && pend_v_r) begin
      strobe_nxt = 1'b1;
      kind_nxt = mpt_pkg::KIND_FIRE;
      status_nxt = mpt_pkg::ST_OK;
      rid_nxt = mpt_pkg::slot_to_id(pend_id_r);
      obase_nxt = base_r;
      last_nxt = 1'b1;
    end

    // Scan: wanted rate over the slots that stay active, first free slot.
    if (cmd.scan_pr) begin
      if (active_r[idx_r] && !(!set_r && (idx_r == id_r))) begin
        acc_nxt = mpt_pkg::merge_rate(acc_r, rword.freq);
      end
      if (!active_r[idx_r] && !free_r) begin
        free_nxt = 1'b1;
        slot_nxt = idx_r;
      end
    end

    if (cmd.commit) begin
      base_nxt = new_rate;
      idx_nxt = '0;
      if (set_r) begin
        active_nxt[slot_r] = 1'b1;
        we = 1'b1;
        waddr = slot_r;
        wdata.freq = freq_r;
        wdata.count = '0;
        wdata.period = '0;
      end else begin
        active_nxt[id_r] = 1'b0;
      end
    end

    if (cmd.rt_wr) begin
      we = 1'b1;
      wdata.count = '0;
      wdata.period = quo;
    end

    if (cmd.np_wr) begin
      we = 1'b1;
      waddr = slot_r;
      wdata.freq = freq_r;
      wdata.count = '0;
      wdata.period = quo;
    end

    if (cmd.emit_ack) begin
      strobe_nxt = 1'b1;
      kind_nxt = mpt_pkg::KIND_ACK;
      status_nxt = cmd.ack_status;
      rid_nxt = ((cmd.ack_status == mpt_pkg::ST_OK) && set_r) ?
                mpt_pkg::slot_to_id(slot_r) : '0;
      obase_nxt = base_r;
      last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      base_r <= '0;
      strobe_r <= 1'b0;
      pend_v_r <= 1'b0;
      fires_r <= '0;
      idx_r <= '0;
    end else begin
      active_r <= active_nxt;
      base_r <= base_nxt;
      strobe_r <= strobe_nxt;
      pend_v_r <= pend_v_nxt;
      fires_r <= fires_nxt;
      idx_r <= idx_nxt;
    end
    id_r <= id_nxt;
    slot_r <= slot_nxt;
    pend_id_r <= pend_id_nxt;
    set_r <= set_nxt;
    free_r <= free_nxt;
    freq_r <= freq_nxt;
    acc_r <= acc_nxt;
    kind_r <= kind_nxt;
    status_r <= status_nxt;
    rid_r <= rid_nxt;
    obase_r <= obase_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_kind = kind_r;
  assign out_status = status_r;
  assign out_result_id = rid_r;
  assign out_base_rate_hz = obase_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

### rtl/mpt_ctrl.sv
// Controller state machine of the timers: sequences tick, scan, retune
// and new-period passes over the slots. Depends on mpt_pkg.
`default_nettype none
module mpt_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire  mpt_pkg::stat_t st,
  output mpt_pkg::cmd_t        cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TK_RD = 4'd1;
  localparam logic [3:0] S_TK_PR = 4'd2;
  localparam logic [3:0] S_TK_END = 4'd3;
  localparam logic [3:0] S_SC_RD = 4'd4;
  localparam logic [3:0] S_SC_PR = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_RT_RD = 4'd7;
  localparam logic [3:0] S_RT_PR = 4'd8;
  localparam logic [3:0] S_RT_DIV = 4'd9;
  localparam logic [3:0] S_NP_DIV = 4'd10;
  localparam logic [3:0] S_ACK = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.ack_status = mpt_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (st.in_tick) begin
            cmd.load = 1'b1;
            state_nxt = S_TK_RD;
          end else if (st.in_setdel && st.in_bad) begin
            cmd.emit_ack = 1'b1;
            cmd.ack_status = mpt_pkg::ST_INVALID;
          end else if (st.in_setdel) begin
            cmd.load = 1'b1;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_TK_RD: state_nxt = S_TK_PR;
      S_TK_PR: begin
        cmd.tick_pr = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_TK_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_TK_RD;
        end
      end
      S_TK_END: begin
        cmd.tick_end = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SC_RD: state_nxt = S_SC_PR;
      S_SC_PR: begin
        cmd.scan_pr = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SC_RD;
        end
      end
      S_DECIDE: begin
        if (st.full) begin
          cmd.emit_ack = 1'b1;
          cmd.ack_status = mpt_pkg::ST_NOFREE;
          state_nxt = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          if (st.rate_chg && !st.rate_zero) begin
            state_nxt = S_RT_RD;
          end else if (st.is_set) begin
            cmd.div_start = 1'b1;
            cmd.div_new = 1'b1;
            state_nxt = S_NP_DIV;
          end else begin
            state_nxt = S_ACK;
          end
        end
      end
      S_RT_RD: state_nxt = S_RT_PR;
      S_RT_PR: begin
        if (st.idx_active) begin
          cmd.div_start = 1'b1;
          state_nxt = S_RT_DIV;
        end else if (st.idx_last) begin
          state_nxt = S_ACK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_RT_RD;
        end
      end
      S_RT_DIV: begin
        if (st.div_done) begin
          cmd.rt_wr = 1'b1;
          if (st.idx_last) begin
            state_nxt = S_ACK;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt = S_RT_RD;
          end
        end
      end
      S_NP_DIV: begin
        if (st.div_done) begin
          cmd.np_wr = 1'b1;
          state_nxt = S_ACK;
        end
      end
      S_ACK: begin
        cmd.emit_ack = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

### rtl/multiplexed_periodic_timers.sv
// Top level of the multiplexed periodic timers: controller plus datapath.
// Depends on mpt_pkg, mpt_ctrl and mpt_datapath.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+-------------------
//   command   | in_op, in_freq_hz, in_timer_id               | start high, busy low
//   result    | out_kind, out_status, out_result_id,         | out_strobe, one
//             | out_base_rate_hz, out_last                   | cycle, no stall
//
// Each word is handled one at a time; busy stays high until its work is done.
// A tick walks every slot through the slot RAM's single read port, reading
// and then processing each slot in turn, then sends the last fire. A
// set or delete first scans all slots. A set then writes one new period
// through the 10-step divider; when the base rate changes to a nonzero
// value, every active slot is retuned through the divider instead.
// Reset is synchronous and active low; it frees every slot and stops the base.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module multiplexed_periodic_timers (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [1:0]                    in_op,
  input  wire  [mpt_pkg::FREQ_IN_W-1:0] in_freq_hz,
  input  wire  [mpt_pkg::ID_IN_W-1:0]   in_timer_id,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic [1:0]                    out_status,
  output logic [mpt_pkg::RES_ID_W-1:0]  out_result_id,
  output logic [mpt_pkg::RATE_W-1:0]    out_base_rate_hz,
  output logic                          out_last
);

  // Command and status between the sequencer and the datapath.
  mpt_pkg::cmd_t  cmd;
  mpt_pkg::stat_t st;

  // The controller decides what each cycle does; it never touches data.
  mpt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  // The datapath holds slots, base rate, divider and the result registers.
  // Fires are delayed by one step so the final fire of a tick gets out_last.
  mpt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_op),
    .in_freq_hz      (in_freq_hz),
    .in_timer_id     (in_timer_id),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_base_rate_hz(out_base_rate_hz),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
